>>> rtl/core/urfd_pkg.sv
package urfd_pkg;

    localparam int FIFO_DEPTH  = 32;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int LEVEL_W     = 6;

    localparam logic       CMD_PUSH    = 1'b0;
    localparam logic       CMD_POP     = 1'b1;
    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_BYTE   = 8'h55;
    localparam logic [1:0] PAYLOAD_LEN = 2'd2;

    // per-item status carried from the fifo stage to the parse stage
    typedef struct packed {
        logic               push_accepted;
        logic               pop_valid;
        logic [LEVEL_W-1:0] level;
    } t_fifo_info;

    // parser verdict for the current byte
    typedef struct packed {
        logic       done;
        logic [7:0] command;
        logic [7:0] argument;
    } t_frame;

endpackage

>>> rtl/core/uart_rx_fifo_frame_deframer.sv
// channel  direction  handshake            payload
// input    in         i_valid / o_ready    i_command, i_rx_byte
// result   out        o_valid / i_ready    o_push_accepted, o_pop_valid, o_popped_byte,
//                                          o_frame_done, o_frame_command,
//                                          o_frame_argument, o_fifo_level
//
// one transfer per cycle sustained while the result channel is not stalled; a result leaves by way of
// the fifo stage with the registered byte store read, then the parser step into the output register
// reset is synchronous, active low; the byte store itself is not cleared
// a stalled result holds the parse stage; input is still taken while the parse stage is free
module uart_rx_fifo_frame_deframer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_command,
    input  logic [7:0]                   i_rx_byte,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_push_accepted,
    output logic                         o_pop_valid,
    output logic [7:0]                   o_popped_byte,
    output logic                         o_frame_done,
    output logic [7:0]                   o_frame_command,
    output logic [7:0]                   o_frame_argument,
    output logic [urfd_pkg::LEVEL_W-1:0] o_fifo_level
);
    import urfd_pkg::*;

    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_s1_move;
    logic               r_s1_valid;
    logic               r_out_valid;
    t_fifo_info         w_info;
    logic [7:0]         w_rd_data;
    t_frame             w_frame;
    logic               r_push_accepted;
    logic               r_pop_valid;
    logic [7:0]         r_popped_byte;
    logic               r_frame_done;
    logic [7:0]         r_frame_command;
    logic [7:0]         r_frame_argument;
    logic [LEVEL_W-1:0] r_fifo_level;

    // output register empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_ready;
    // parse stage hands its item to the output register
    assign w_s1_move  = r_s1_valid && w_out_free;
    // fifo stage takes a new item when the parse stage is empty or moving on
    assign o_ready    = !r_s1_valid || w_out_free;
    assign w_in_xfer  = i_valid && o_ready;

    urfd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_in_xfer),
        .i_command (i_command),
        .i_rx_byte (i_rx_byte),
        .o_info    (w_info),
        .o_rd_data (w_rd_data)
    );

    // parser steps only on a pop that found a byte
    urfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_s1_move && w_info.pop_valid),
        .i_byte  (w_rd_data),
        .o_frame (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, zeroed fields where the item did not pop or complete a frame
    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_push_accepted  <= w_info.push_accepted;
            r_pop_valid      <= w_info.pop_valid;
            r_popped_byte    <= w_info.pop_valid ? w_rd_data : 8'h00;
            r_frame_done     <= w_info.pop_valid && w_frame.done;
            r_frame_command  <= (w_info.pop_valid && w_frame.done) ? w_frame.command : 8'h00;
            r_frame_argument <= (w_info.pop_valid && w_frame.done) ? w_frame.argument : 8'h00;
            r_fifo_level     <= w_info.level;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_push_accepted  = r_push_accepted;
    assign o_pop_valid      = r_pop_valid;
    assign o_popped_byte    = r_popped_byte;
    assign o_frame_done     = r_frame_done;
    assign o_frame_command  = r_frame_command;
    assign o_frame_argument = r_frame_argument;
    assign o_fifo_level     = r_fifo_level;

endmodule

>>> rtl/core/urfd_fifo.sv
module urfd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_command,
    input  logic [7:0]            i_rx_byte,
    output urfd_pkg::t_fifo_info  o_info,
    output logic [7:0]            o_rd_data
);
    import urfd_pkg::*;

    logic [7:0]       r_mem [FIFO_DEPTH];
    logic [7:0]       r_rd_data;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_fifo_info       r_info;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign w_push_ok = (i_command == CMD_PUSH) && (r_count < CNT_W'(FIFO_DEPTH));
    assign w_pop_ok  = (i_command == CMD_POP) && (r_count != '0);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (w_push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end else if (w_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // byte store: one write or one read per transfer, read data registered
    always_ff @(posedge i_clk) begin
        if (i_accept && w_push_ok) begin
            r_mem[r_wr_ptr] <= i_rx_byte;
        end
        if (i_accept && w_pop_ok) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_info.push_accepted <= w_push_ok;
            r_info.pop_valid     <= w_pop_ok;
            r_info.level         <= LEVEL_W'(n_count);
        end
    end

    assign o_info    = r_info;
    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/urfd_parser.sv
module urfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output urfd_pkg::t_frame o_frame
);
    import urfd_pkg::*;

    typedef enum logic [4:0] {
        PH_HUNT1 = 5'b00001,
        PH_HUNT2 = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_TAIL1 = 5'b01000,
        PH_TAIL2 = 5'b10000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_pay0, n_pay0;
    logic [7:0] r_pay1, n_pay1;
    logic [1:0] r_pcnt, n_pcnt;
    t_frame     w_frame;

    always_comb begin
        n_phase = r_phase;
        n_pay0  = r_pay0;
        n_pay1  = r_pay1;
        n_pcnt  = r_pcnt;
        w_frame = '0;
        case (r_phase)
            PH_HUNT2: begin
                if (i_byte == HEADER_BYTE) begin
                    n_phase = PH_DATA;
                    n_pcnt  = '0;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_DATA: begin
                if (r_pcnt[0]) begin
                    n_pay1 = i_byte;
                end else begin
                    n_pay0 = i_byte;
                end
                n_pcnt = r_pcnt + 2'd1;
                if (n_pcnt == PAYLOAD_LEN) begin
                    n_phase = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                n_phase = (i_byte == TAIL_BYTE) ? PH_TAIL2 : PH_HUNT1;
            end
            PH_TAIL2: begin
                n_phase = PH_HUNT1;
                if (i_byte == TAIL_BYTE) begin
                    w_frame.done     = 1'b1;
                    w_frame.command  = r_pay0;
                    w_frame.argument = r_pay1;
                    n_pay0           = '0;
                    n_pay1           = '0;
                    n_pcnt           = '0;
                end
            end
            default: begin
                n_phase = (i_byte == HEADER_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_pay0  <= '0;
            r_pay1  <= '0;
            r_pcnt  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pay0  <= n_pay0;
            r_pay1  <= n_pay1;
            r_pcnt  <= n_pcnt;
        end
    end

    assign o_frame = w_frame;

endmodule
